// ----- sv/vfs_pkg.sv -----
package vfs_pkg;

  // store geometry
  localparam int unsigned SlotCount = 512;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned DataW     = 64;
  localparam int unsigned EncW      = 15;
  localparam int unsigned HalfW     = DataW / 2;

  localparam logic [SlotW-1:0] SlotZeroAlias = SlotW'(9'h03f);
  localparam logic [4:0]       IndexMask     = 5'h1f;

  // width field of the encoding
  typedef enum logic [1:0] {
    WIDTH_16  = 2'd0,
    WIDTH_64  = 2'd1,
    WIDTH_32  = 2'd2,
    WIDTH_NAT = 2'd3
  } width_e;

  // action codes
  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  // clearing sequencer status, seen by the top level
  typedef struct packed {
    logic             busy;
    logic [SlotW-1:0] addr;
  } clr_t;

  // slot of an encoding: index low bits, type, width; slot 0 aliases 0x3f
  function automatic logic [SlotW-1:0] slot_of(input logic [EncW-1:0] enc);
    logic [SlotW-1:0] slot;
    slot = {enc[14:13], enc[11:10], enc[5:1] & IndexMask};
    if (slot == '0) begin
      slot = SlotZeroAlias;
    end
    return slot;
  endfunction

  // value returned by a read of a field
  function automatic logic [DataW-1:0] read_of(input logic [EncW-1:0] enc,
                                               input logic [DataW-1:0] cur);
    logic [DataW-1:0] res;
    case (width_e'(enc[14:13]))
      WIDTH_16: res = {48'd0, cur[15:0]};
      WIDTH_64: res = enc[0] ? {32'd0, cur[DataW-1:HalfW]} : cur;
      WIDTH_32: res = {32'd0, cur[HalfW-1:0]};
      default:  res = cur;
    endcase
    return res;
  endfunction

  // new slot contents for a write of a field
  function automatic logic [DataW-1:0] write_of(input logic [EncW-1:0] enc,
                                                input logic [DataW-1:0] cur,
                                                input logic [DataW-1:0] val);
    logic [DataW-1:0] res;
    case (width_e'(enc[14:13]))
      WIDTH_16: res = {48'd0, val[15:0]};
      WIDTH_64: res = enc[0] ? {val[HalfW-1:0], cur[HalfW-1:0]} : val;
      WIDTH_32: res = {32'd0, val[HalfW-1:0]};
      default:  res = val;
    endcase
    return res;
  endfunction

endpackage

// ----- sv/vfs_if.sv -----
// request channel: one field access per beat
interface vfs_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [vfs_pkg::EncW-1:0]   field_encoding;
  logic [vfs_pkg::DataW-1:0]  write_value;

  modport source (output valid, action, field_encoding, write_value, input ready);
  modport sink   (input valid, action, field_encoding, write_value, output ready);
endinterface

// response channel: one read value per beat
interface vfs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [vfs_pkg::DataW-1:0]  read_value;

  modport source (output valid, read_value, input ready);
  modport sink   (input valid, read_value, output ready);
endinterface

// ----- sv/vfs_ram.sv -----
module vfs_ram #(
  parameter int unsigned Width = vfs_pkg::DataW,
  parameter int unsigned Depth = vfs_pkg::SlotCount,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/vfs_clear.sv -----
module vfs_clear (
  input  logic          clk_i,
  input  logic          rst_ni,
  output vfs_pkg::clr_t clr_o
);

  logic                      busy_q, busy_d;
  logic [vfs_pkg::SlotW-1:0] addr_q, addr_d;

  // walk every slot once after reset
  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      addr_d = addr_q + 1'b1;
      if (addr_q == vfs_pkg::SlotW'(vfs_pkg::SlotCount - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign clr_o.busy = busy_q;
  assign clr_o.addr = addr_q;

endmodule

// ----- sv/vmcs_field_store_core.sv -----
// channel | dir | beat contents
// --------+-----+------------------------------------------------
// req_i   | in  | action, field_encoding (15b), write_value (64b)
// rsp_o   | out | read_value (64b), zero for a write
//
// One request beat per cycle while rsp_o accepts; each result passes through
// the slot memory read, then the update and output register.
// Back-to-back accesses to one slot are served by a one-entry forward path
// around the memory's registered read.
// After reset a clearing pass zeroes all 512 slots, one per cycle; req_i
// stays not ready until the pass is done.
// A stalled rsp_o holds the item in flight and backs up req_i.
module vmcs_field_store_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  vfs_req_if.sink    req_i,
  vfs_rsp_if.source  rsp_o
);

  localparam int unsigned SlotW = vfs_pkg::SlotW;

  vfs_pkg::clr_t clr;

  // stage 1: item whose slot data is being read
  logic                       s1_valid_q;
  logic                       s1_action_q;
  logic [vfs_pkg::EncW-1:0]   s1_enc_q;
  logic [vfs_pkg::DataW-1:0]  s1_val_q;
  logic [SlotW-1:0]           s1_slot_q;

  // forward path for a write just ahead of the read
  logic                       fwd_hit_q, fwd_hit_d;
  logic [vfs_pkg::DataW-1:0]  fwd_data_q;

  // output register
  logic                       out_valid_q;
  logic [vfs_pkg::DataW-1:0]  out_data_q;

  logic                       s1_fire, in_fire, s1_write;
  logic [SlotW-1:0]           in_slot;
  logic [vfs_pkg::DataW-1:0]  ram_rdata, cur, new_val, rd_val;
  logic                       ram_we;
  logic [SlotW-1:0]           ram_waddr;
  logic [vfs_pkg::DataW-1:0]  ram_wdata;

  vfs_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  // handshake
  assign s1_fire     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clr.busy && (!s1_valid_q || s1_fire);
  assign in_fire     = req_i.valid && req_i.ready;
  assign in_slot     = SlotW'(vfs_pkg::slot_of(req_i.field_encoding));

  // field update and read value
  assign s1_write = (s1_action_q == vfs_pkg::ACT_WRITE);
  assign cur      = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign new_val  = vfs_pkg::write_of(s1_enc_q, cur, s1_val_q);
  assign rd_val   = s1_write ? '0 : vfs_pkg::read_of(s1_enc_q, cur);

  // memory write: clearing pass, else the retiring write
  assign ram_we    = clr.busy || (s1_fire && s1_write);
  assign ram_waddr = clr.busy ? SlotW'(clr.addr) : s1_slot_q;
  assign ram_wdata = clr.busy ? '0 : new_val;

  vfs_ram #(
    .Width (vfs_pkg::DataW),
    .Depth (vfs_pkg::SlotCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_slot),
    .rdata_o (ram_rdata)
  );

  // forward when the incoming beat reads the slot being written now
  assign fwd_hit_d = s1_fire && s1_write && (s1_slot_q == in_slot);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= fwd_hit_d;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= req_i.action;
      s1_enc_q    <= req_i.field_encoding;
      s1_val_q    <= req_i.write_value;
      s1_slot_q   <= in_slot;
      fwd_data_q  <= new_val;
    end
    if (s1_fire) begin
      out_data_q <= rd_val;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_data_q;

endmodule

// ----- test/vmcs_field_store_core_test.sv -----
`timescale 1ns / 100ps

module vmcs_field_store_core_test;
  import vfs_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldLen    = 400;
  localparam int unsigned DrainWait  = 8;

  // shadow copy of the field slots and the read values still owed
  class field_store_sb;
    logic [DataW-1:0] slots [SlotCount];
    logic [DataW-1:0] pending_reads [$];
    int unsigned      errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      errors = 0;
    endfunction

    // work out the read value of one accepted request beat, and update the shadow slot for a write
    function void note_access(action_e act, logic [EncW-1:0] enc,
                              logic [DataW-1:0] val);
      width_e           w;
      logic             high;
      logic [SlotW-1:0] slot;
      logic [DataW-1:0] cur;
      logic [DataW-1:0] res;
      w    = width_e'(enc[14:13]);
      high = enc[0];
      slot = {enc[14:13], enc[11:10], enc[5:1]};
      if (slot == '0) begin
        slot = SlotZeroAlias;
      end
      cur = slots[slot];
      if (act == ACT_READ) begin
        case (w)
          WIDTH_16: res = cur & 64'h0000_0000_0000_ffff;
          WIDTH_64: res = high ? (cur >> 32) : cur;
          WIDTH_32: res = cur & 64'h0000_0000_ffff_ffff;
          default:  res = cur;
        endcase
        pending_reads.push_back(res);
      end else begin
        case (w)
          WIDTH_16: res = val & 64'h0000_0000_0000_ffff;
          WIDTH_64: res = high ? {val[31:0], cur[31:0]} : val;
          WIDTH_32: res = val & 64'h0000_0000_ffff_ffff;
          default:  res = val;
        endcase
        slots[slot] = res;
        pending_reads.push_back('0);
      end
    endfunction

    // compare one response beat with the oldest expectation
    function void check_read(logic [DataW-1:0] got);
      logic [DataW-1:0] expected;
      if (pending_reads.size() == 0) begin
        $error("read_value: beat with nothing expected, actual %h", got);
        errors++;
      end else begin
        expected = pending_reads.pop_front();
        if (got !== expected) begin
          $error("read_value: expected %h actual %h", expected, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  vfs_req_if req_bus ();
  vfs_rsp_if rsp_bus ();

  vmcs_field_store_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  field_store_sb    sb;
  int unsigned      send_idle_pct;
  int unsigned      rcv_idle_pct;
  bit               rsp_hold_req;
  int unsigned      stall_cnt;
  logic [EncW-1:0]  last_enc;
  logic [EncW-1:0]  enc_pool [8];

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // field encoding from its parts, reserved bit clear
  function automatic logic [EncW-1:0] enc_of(width_e w, logic [1:0] typ,
                                             logic [8:0] idx, logic high);
    return {w, 1'b0, typ, idx, high};
  endfunction

  // offer one request beat, idling first; returns at the falling edge after acceptance
  task automatic send_access(action_e act, logic [EncW-1:0] enc, logic [DataW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid          <= 1'b1;
    req_bus.action         <= act;
    req_bus.field_encoding <= enc;
    req_bus.write_value    <= val;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sb.note_access(act, enc, val);
    last_enc = enc;
    @(negedge clk);
  endtask

  // random access, mostly to a few hot fields so reads find written data
  task automatic random_access();
    logic [EncW-1:0]  enc;
    logic [DataW-1:0] val;
    action_e          act;
    case ($urandom_range(3))
      0:       enc = EncW'($urandom_range(32767));
      3:       enc = last_enc;
      default: enc = enc_pool[$urandom_range(7)];
    endcase
    case ($urandom_range(7))
      0:       val = '0;
      1:       val = '1;
      default: val = {$urandom, $urandom};
    endcase
    act = action_e'($urandom_range(1));
    send_access(act, enc, val);
  endtask

  task automatic fill_pool();
    enc_pool[0] = 15'h0000;
    enc_pool[1] = enc_of(WIDTH_16, 2'd1, 9'd31, 1'b0);
    for (int i = 2; i < 8; i++) begin
      enc_pool[i] = enc_of(width_e'($urandom_range(3)), 2'($urandom_range(3)),
                           9'($urandom_range(511)), 1'($urandom_range(1)));
    end
  endtask

  // response side: random back-pressure plus a long hold when requested
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold_left    = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // check every response beat
  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      sb.check_read(rsp_bus.read_value);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus
  initial begin
    sb                     = new();
    stall_cnt              = 0;
    rsp_hold_req           = 1'b0;
    last_enc               = '0;
    send_idle_pct          = 23;
    rcv_idle_pct           = 66;
    rst_n                  = 1'b0;
    req_bus.valid          = 1'b0;
    req_bus.action         = ACT_READ;
    req_bus.field_encoding = '0;
    req_bus.write_value    = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, both actions, aliasing and width cases
    send_access(ACT_READ,  15'h0000, '0);
    send_access(ACT_WRITE, enc_of(WIDTH_NAT, 2'd3, 9'd31, 1'b0), '1);
    send_access(ACT_READ,  enc_of(WIDTH_NAT, 2'd3, 9'd31, 1'b0), '0);
    send_access(ACT_WRITE, enc_of(WIDTH_16, 2'd0, 9'd5, 1'b0), '1);
    send_access(ACT_READ,  enc_of(WIDTH_16, 2'd0, 9'd5, 1'b0), '1);
    // high bit on a 16-bit field is ignored
    send_access(ACT_READ,  enc_of(WIDTH_16, 2'd0, 9'd5, 1'b1), '0);
    // reserved bit set
    send_access(ACT_READ,  enc_of(WIDTH_16, 2'd0, 9'd5, 1'b0) | 15'h1000, '0);
    send_access(ACT_WRITE, enc_of(WIDTH_32, 2'd2, 9'd7, 1'b1), 64'hdead_beef_cafe_f00d);
    // upper index bits alias the low five
    send_access(ACT_READ,  enc_of(WIDTH_32, 2'd2, 9'd423, 1'b0), '0);
    send_access(ACT_WRITE, enc_of(WIDTH_64, 2'd1, 9'd3, 1'b0), 64'h0123_4567_89ab_cdef);
    send_access(ACT_WRITE, enc_of(WIDTH_64, 2'd1, 9'd3, 1'b1), 64'hffff_ffff_a5a5_a5a5);
    send_access(ACT_READ,  enc_of(WIDTH_64, 2'd1, 9'd3, 1'b0), '0);
    send_access(ACT_READ,  enc_of(WIDTH_64, 2'd1, 9'd3, 1'b1), '1);
    // slot zero shares the aliased slot
    send_access(ACT_WRITE, 15'h0000, 64'h1234_5678_9abc_def0);
    send_access(ACT_READ,  enc_of(WIDTH_16, 2'd1, 9'd31, 1'b0), '0);
    send_access(ACT_WRITE, enc_of(WIDTH_16, 2'd1, 9'd31, 1'b0), 64'hffff_0000_ffff_7777);
    send_access(ACT_READ,  15'h0000, '0);
    send_access(ACT_WRITE, 15'h7fff, '1);
    send_access(ACT_READ,  enc_of(WIDTH_NAT, 2'd3, 9'd31, 1'b0), '0);
    send_access(ACT_WRITE, enc_of(WIDTH_64, 2'd0, 9'd0, 1'b1), '1);
    send_access(ACT_READ,  enc_of(WIDTH_64, 2'd0, 9'd0, 1'b0), '0);
    send_access(ACT_WRITE, enc_of(WIDTH_NAT, 2'd0, 9'd0, 1'b0), '0);
    send_access(ACT_READ,  enc_of(WIDTH_NAT, 2'd0, 9'd0, 1'b0), '1);

    // random: slow receiver
    fill_pool();
    repeat (250) random_access();

    // random: slow sender
    send_idle_pct = 66;
    rcv_idle_pct  = 23;
    fill_pool();
    repeat (250) random_access();

    // random: no idling, with one long response hold to back up the input
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    fill_pool();
    for (int i = 0; i < 200; i++) begin
      if (i == 40) begin
        rsp_hold_req = 1'b1;
      end
      random_access();
    end
    req_bus.valid <= 1'b0;

    // drain
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (sb.errors == 0 && sb.pending_reads.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
